@@ design/jsud_pkg.sv @@
// Shared types, codes and the hex-digit helper function of the JSON string unescape decoder.
package jsud_pkg;

  // Kind of a result beat.
  typedef enum logic [1:0] {
    KindByte  = 2'd0,
    KindEnd   = 2'd1,
    KindError = 2'd2
  } kind_e;

  // Error codes carried on an error beat.
  typedef enum logic [1:0] {
    ErrNoQuote = 2'd0,
    ErrBadHex  = 2'd1,
    ErrBadEsc  = 2'd2,
    ErrControl = 2'd3
  } err_e;

  // Parser state, one-hot.
  typedef enum logic [3:0] {
    ModeIdle = 4'b0001,
    ModeStr  = 4'b0010,
    ModeEsc  = 4'b0100,
    ModeHex  = 4'b1000
  } mode_e;

  // Characters the parser recognizes.
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChLowB      = 8'h62;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChLowN      = 8'h6E;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowU      = 8'h75;
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChFormFeed  = 8'h0C;
  localparam logic [7:0] CtrlLimit   = 8'h20;

  // One command from the parser to the output expander.
  typedef struct packed {
    logic        is_cp;  // expand cp into UTF-8 bytes
    kind_e       kind;
    logic [7:0]  data;
    err_e        err;
    logic [15:0] cp;
  } cmd_t;

  // Hex digit decode: bit 4 set when the byte is a hex digit, bits 3:0 its value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

@@ design/jsud_front.sv @@
// Parser front end: takes raw bytes, tracks string and escape state, issues commands.
module jsud_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          q_ready_i,
  output logic          q_push_o,
  output jsud_pkg::cmd_t q_cmd_o
);
  import jsud_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [4:0]  hv;
  logic        is_ws;
  logic        accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign hv         = hex_val(in_byte_i);
  assign is_ws      = (in_byte_i == ChSpace) || (in_byte_i == ChLf) ||
                      (in_byte_i == ChCr) || (in_byte_i == ChTab);

  // Next state and command for the accepted byte.
  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    q_push_o = 1'b0;
    q_cmd_o  = '0;
    q_cmd_o.kind = KindByte;
    q_cmd_o.err  = ErrNoQuote;
    if (accept) begin
      unique case (mode_q)
        ModeIdle: begin
          if (in_byte_i == ChQuote) begin
            mode_d = ModeStr;
          end else if (!is_ws) begin
            q_push_o     = 1'b1;
            q_cmd_o.kind = KindError;
            q_cmd_o.err  = ErrNoQuote;
          end
        end
        ModeStr: begin
          if (in_byte_i == ChBackslash) begin
            mode_d = ModeEsc;
          end else if (in_byte_i == ChQuote) begin
            mode_d       = ModeIdle;
            q_push_o     = 1'b1;
            q_cmd_o.kind = KindEnd;
          end else if (in_byte_i < CtrlLimit) begin
            mode_d       = ModeIdle;
            cnt_d        = 2'd0;
            acc_d        = 16'd0;
            q_push_o     = 1'b1;
            q_cmd_o.kind = KindError;
            q_cmd_o.err  = ErrControl;
          end else begin
            q_push_o     = 1'b1;
            q_cmd_o.data = in_byte_i;
          end
        end
        ModeEsc: begin
          mode_d   = ModeStr;
          q_push_o = 1'b1;
          unique case (in_byte_i)
            ChQuote:     q_cmd_o.data = ChQuote;
            ChBackslash: q_cmd_o.data = ChBackslash;
            ChSlash:     q_cmd_o.data = ChSlash;
            ChLowB:      q_cmd_o.data = ChBackspace;
            ChLowF:      q_cmd_o.data = ChFormFeed;
            ChLowN:      q_cmd_o.data = ChLf;
            ChLowR:      q_cmd_o.data = ChCr;
            ChLowT:      q_cmd_o.data = ChTab;
            ChLowU: begin
              mode_d   = ModeHex;
              cnt_d    = 2'd0;
              acc_d    = 16'd0;
              q_push_o = 1'b0;
            end
            default: begin
              mode_d       = ModeIdle;
              cnt_d        = 2'd0;
              acc_d        = 16'd0;
              q_cmd_o.kind = KindError;
              q_cmd_o.err  = ErrBadEsc;
            end
          endcase
        end
        ModeHex: begin
          if (!hv[4]) begin
            mode_d       = ModeIdle;
            cnt_d        = 2'd0;
            acc_d        = 16'd0;
            q_push_o     = 1'b1;
            q_cmd_o.kind = KindError;
            q_cmd_o.err  = ErrBadHex;
          end else if (cnt_q == 2'd3) begin
            // Fourth digit completes the code point.
            mode_d        = ModeStr;
            cnt_d         = 2'd0;
            acc_d         = 16'd0;
            q_push_o      = 1'b1;
            q_cmd_o.is_cp = 1'b1;
            q_cmd_o.cp    = {acc_q[11:0], hv[3:0]};
          end else begin
            cnt_d = cnt_q + 2'd1;
            acc_d = {acc_q[11:0], hv[3:0]};
          end
        end
        default: begin
          mode_d = ModeIdle;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      cnt_q  <= 2'd0;
      acc_q  <= 16'd0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
    end
  end

endmodule

@@ design/jsud_fifo.sv @@
// Short command queue between the parser and the output expander.
module jsud_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jsud_pkg::cmd_t push_cmd_i,
  output logic           ready_o,
  output logic           valid_o,
  output jsud_pkg::cmd_t head_o,
  input  logic           pop_i
);
  import jsud_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ design/jsud_back.sv @@
// Output expander: turns queued commands into result beats, UTF-8 encoding code points.
module jsud_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  jsud_pkg::cmd_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     result_kind_o,
  output logic [7:0]     out_byte_o,
  output logic [1:0]     error_code_o,
  output logic           last_of_run_o
);
  import jsud_pkg::*;

  logic [1:0]  step_q, step_d;
  logic [1:0]  last_step;
  logic [7:0]  beat_byte;
  logic        beat_last;
  logic        load;
  logic        valid_q, valid_d;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic [1:0]  err_q;
  logic        last_q;
  logic [15:0] cp;

  assign cp = q_head_i.cp;

  // Number of beats of the head command, less one.
  always_comb begin
    if (!q_head_i.is_cp || cp[15:7] == 9'd0) begin
      last_step = 2'd0;
    end else if (cp[15:11] == 5'd0) begin
      last_step = 2'd1;
    end else begin
      last_step = 2'd2;
    end
  end

  // Byte of the current beat.
  always_comb begin
    beat_byte = q_head_i.data;
    if (q_head_i.is_cp) begin
      case (last_step)
        2'd0: beat_byte = cp[7:0];
        2'd1: beat_byte = (step_q == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
        default: begin
          case (step_q)
            2'd0:    beat_byte = {4'b1110, cp[15:12]};
            2'd1:    beat_byte = {2'b10, cp[11:6]};
            default: beat_byte = {2'b10, cp[5:0]};
          endcase
        end
      endcase
    end
  end

  assign beat_last = (step_q == last_step);
  assign load      = q_valid_i && (!valid_q || out_ready_i);
  assign q_pop_o   = load && beat_last;

  // Beat counter within a command and output valid.
  always_comb begin
    step_d  = step_q;
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      step_d  = beat_last ? 2'd0 : step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= q_head_i.kind;
      byte_q <= beat_byte;
      err_q  <= q_head_i.err;
      last_q <= beat_last;
    end
  end

  assign out_valid_o   = valid_q;
  assign result_kind_o = kind_q;
  assign out_byte_o    = byte_q;
  assign error_code_o  = err_q;
  assign last_of_run_o = last_q;

endmodule

@@ design/json_string_unescape_decoder.sv @@
// An accepted byte's command is written into the command queue, then loaded into the output register as a result beat.
// Throughput: one input byte per cycle while the queue has room; one result beat per cycle while out_ready_i is high.
// A \uXXXX escape gives up to three beats from six input bytes, so the queue keeps up.
// Reset (rst_ni low, asynchronous): parser idle awaiting a quote, queue empty, no beat shown.
module json_string_unescape_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] error_code_o,
  output logic       last_of_run_o
);
  import jsud_pkg::*;

  logic q_push, q_ready, q_valid, q_pop;
  cmd_t push_cmd, head_cmd;

  // Parser front end.
  jsud_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  // Command queue.
  jsud_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .head_o     (head_cmd),
    .pop_i      (q_pop)
  );

  // Output expander.
  jsud_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (head_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .out_byte_o    (out_byte_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

@@ design/jsud_checker.sv @@
// Port-level checks of the JSON string unescape decoder and their binding.
module jsud_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] result_kind_o,
  input logic [7:0] out_byte_o,
  input logic [1:0] error_code_o,
  input logic       last_of_run_o
);
  import jsud_pkg::*;

  // A stalled beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) &&
    $stable(out_byte_o) && $stable(error_code_o) && $stable(last_of_run_o))
    else $error("stalled result beat changed");

  // End and error beats are always the only beat of their byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KindEnd || result_kind_o == KindError)
    |-> last_of_run_o)
    else $error("end or error beat not marked last");

  // Fields unused by a beat's kind read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KindByte |-> out_byte_o == 8'd0)
    else $error("non-byte beat carries a byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KindError |-> error_code_o == ErrNoQuote)
    else $error("non-error beat carries an error code");

  // The rest of a multi-byte run follows without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside a UTF-8 run");

endmodule

bind json_string_unescape_decoder jsud_checker u_checker (.*);
